[hdl/gof_pkg.sv]
// Shared types, constants and helper functions of the glyph outline flattener.
package gof_pkg;

  // Datapath widths, step limits and reset values.
  localparam int unsigned MulW        = 33;
  localparam int unsigned SqRadW      = 64;
  localparam int unsigned SqRootW     = 32;
  localparam int unsigned MinSteps    = 2;
  localparam int unsigned MaxStepsDef = 24;
  localparam logic [31:0] InvCapReset = 32'd1497966;

  // Input operation codes.
  typedef enum logic [1:0] {
    OpContour = 2'd0,
    OpLine    = 2'd1,
    OpSpline  = 2'd2,
    OpAdvance = 2'd3
  } op_e;

  // Configuration register indexes.
  localparam logic CfgInvCap = 1'b0;
  localparam logic CfgLetter = 1'b1;

  // Saturate a widened sum to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -34'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Floor of the mean of two signed values.
  function automatic logic signed [31:0] half_floor(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return s[32:1];
  endfunction

  // Signed add of two 32-bit values with saturation.
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat32({{2{a[31]}}, a} + {{2{b[31]}}, b});
  endfunction

endpackage

[hdl/glyph_outline_flattener_top.sv]
// Top level of the glyph outline flattener: sequencer around shared arithmetic units.
//
// Input items carry an operation (contour start, line point, spline point or pen
// advance), a 16.16 point and an advance. An item is taken when in_valid_i is high
// and in_stall_o is low; in_stall_o stays high while an item is being worked on.
// Each result item (scaled point, new_contour, last) is held in an output register
// until the receiver takes it with out_valid_o high and out_stall_i low; a stalled
// receiver simply holds the sequencer in its emit step.
// A pen advance or a buffered spline point stays in the idle step and gives no result.
// A contour start or line point gives one result through the scaling and emit steps.
// A spline segment first measures two legs, each through two products and the
// iterative square root, then the step count. Each interior point needs three
// products and one pass of the shared divider per axis (a DW-bit quotient,
// DW = 42 at the default step limit), then the scaling and emit steps; the
// divider sets the rate of interior points.
// Reset clears the pen, the current point and the spline buffer and loads the
// default scale; the user must write configuration through cfg_we_i only while idle, which the block does not enforce.
module glyph_outline_flattener_top
  import gof_pkg::*;
#(
  parameter int unsigned MAX_STEPS = MaxStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [15:0] advance_i,
  input  logic               last_of_curve_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic               new_contour_o,
  output logic               last_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned StW  = $clog2(MAX_STEPS + 2);
  localparam int unsigned NnW  = $clog2((MAX_STEPS + 1) * (MAX_STEPS + 1) + 1);
  localparam int unsigned NumW = NnW + 33;
  localparam int unsigned DW   = NumW - 1;

  typedef enum logic [4:0] {
    StIdle, StScX, StScY, StScW, StEmit, StLeg, StSqA, StSqB, StSqSum, StSqWait,
    StStMul, StStCalc, StPtA, StPtB, StPtC, StPtD, StPtDiv, StPtNext
  } state_e;

  state_e state_q, ret_q;

  // Configuration and architectural state.
  logic [31:0]        ic_q;
  logic signed [31:0] la_q, pen_q, cur_x_q, cur_y_q;
  logic signed [31:0] pc_x_q [2];
  logic signed [31:0] pc_y_q [2];
  logic [1:0]         cnt_q;

  // Working registers of one item.
  logic signed [31:0] px_q, py_q, c_x_q, c_y_q, e_x_q, e_y_q;
  logic               seg2_q, fin_q, lg_q, hv_q, ax_q, neg_q;
  logic [30:0]        a_q, b_q;
  logic [61:0]        sq_q;
  logic [33:0]        len_q;
  logic [StW-1:0]     st_q, s_q;
  logic signed [NumW-1:0] acc_q;
  logic signed [32:0] em_x_q, em_y_q;
  logic               em_newc_q, em_last_q;
  logic signed [31:0] rx_q, ry_q;

  // Output register.
  logic               out_valid_q, out_newc_q, out_last_q;
  logic signed [31:0] out_x_q, out_y_q;

  // Shared units.
  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [2*MulW-1:0] prod;
  logic                     sq_start, sq_done;
  logic [SqRadW-1:0]        sq_rad;
  logic [SqRootW-1:0]       sq_root;
  logic                     dv_start, dv_done;
  logic [DW-1:0]            dv_dividend, dv_quot;

  gof_mul u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .prod_o(prod));

  gof_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i(sq_rad), .done_o(sq_done),
    .root_o(sq_root)
  );

  logic [NnW-1:0] nn_w;

  gof_div #(.DW(DW), .VW(NnW)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .dividend_i(dv_dividend), .divisor_i(nn_w),
    .done_o(dv_done), .quot_o(dv_quot)
  );

  // Rounded scaling of a magnitude product, then sign and saturation.
  function automatic logic signed [31:0] scale_res(input logic signed [2*MulW-1:0] p,
                                                   input logic neg);
    logic [64:0] sum;
    logic [32:0] r;
    logic [32:0] t;
    sum = {1'b0, p[63:0]} + 65'h080000000;
    r   = sum[64:32];
    t   = -r;
    if (neg) begin
      return t[31:0];
    end
    if (r > 33'h07fffffff) begin
      return 32'sh7fffffff;
    end
    return r[31:0];
  endfunction

  // Interpolation weights of step s out of n.
  logic [StW-1:0]   n_w, nm_w;
  logic [2*StW-1:0] pa, pb, pc, pn;
  logic [NnW-1:0]   coef_a, coef_b, coef_c;

  always_comb begin
    n_w    = st_q + 1'b1;
    nm_w   = n_w - s_q;
    pa     = nm_w * nm_w;
    pb     = nm_w * s_q;
    pc     = s_q * s_q;
    pn     = n_w * n_w;
    coef_a = NnW'(pa);
    coef_b = NnW'({pb, 1'b0});
    coef_c = NnW'(pc);
    nn_w   = NnW'(pn);
  end

  // Leg differences for the current leg.
  logic signed [32:0] dx, dy;
  logic [32:0]        adx, ady;
  logic [33:0]        st_small;
  logic [64:0]        st_v;
  logic [16:0]        st_raw;
  logic signed [NumW-1:0] num;
  logic [NumW-1:0]    num_abs;
  logic [32:0]        q33;
  logic [32:0]        em_ax, em_ay;

  always_comb begin
    if (!lg_q) begin
      dx = {c_x_q[31], c_x_q} - {cur_x_q[31], cur_x_q};
      dy = {c_y_q[31], c_y_q} - {cur_y_q[31], cur_y_q};
    end else begin
      dx = {e_x_q[31], e_x_q} - {c_x_q[31], c_x_q};
      dy = {e_y_q[31], e_y_q} - {c_y_q[31], c_y_q};
    end
    adx      = dx[32] ? -dx : dx;
    ady      = dy[32] ? -dy : dy;
    st_small = ({2'b00, ic_q & {32{len_q[0]}}} + {1'b0, ic_q & {32{len_q[1]}}, 1'b0}) >> 2;
    st_v     = {1'b0, prod[63:0]} + {31'b0, st_small};
    st_raw   = st_v[64:48];
    num      = acc_q + prod[NumW-1:0];
    num_abs  = num[NumW-1] ? -num : num;
    q33      = dv_quot[32:0];
    em_ax    = em_x_q[32] ? -em_x_q : em_x_q;
    em_ay    = em_y_q[32] ? -em_y_q : em_y_q;
  end

  // Operand selection for the shared units.
  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    sq_start    = 1'b0;
    sq_rad      = {1'b0, {1'b0, sq_q} + {1'b0, prod[61:0]}};
    dv_start    = 1'b0;
    dv_dividend = DW'(num_abs) + DW'(nn_w >> 1);
    case (state_q)
      StScX: begin
        mul_a = {1'b0, em_ax[31:0]};
        mul_b = {1'b0, ic_q};
      end
      StScY: begin
        mul_a = {1'b0, em_ay[31:0]};
        mul_b = {1'b0, ic_q};
      end
      StSqA: begin
        mul_a = {2'b00, a_q};
        mul_b = {2'b00, a_q};
      end
      StSqB: begin
        mul_a = {2'b00, b_q};
        mul_b = {2'b00, b_q};
      end
      StSqSum: sq_start = 1'b1;
      StStMul: begin
        mul_a = {1'b0, len_q[33:2]};
        mul_b = {1'b0, ic_q};
      end
      StPtA: begin
        mul_a = ax_q ? {cur_y_q[31], cur_y_q} : {cur_x_q[31], cur_x_q};
        mul_b = MulW'(coef_a);
      end
      StPtB: begin
        mul_a = ax_q ? {c_y_q[31], c_y_q} : {c_x_q[31], c_x_q};
        mul_b = MulW'(coef_b);
      end
      StPtC: begin
        mul_a = ax_q ? {e_y_q[31], e_y_q} : {e_x_q[31], e_x_q};
        mul_b = MulW'(coef_c);
      end
      StPtD: dv_start = 1'b1;
      default: ;
    endcase
  end

  logic signed [33:0] pen_sum;
  assign pen_sum = {{2{pen_q[31]}}, pen_q} + {advance_i[15], advance_i[15], advance_i, 16'b0}
                 + {{2{la_q[31]}}, la_q};

  // Sequencer, architectural state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ret_q       <= StIdle;
      ic_q        <= InvCapReset;
      la_q        <= '0;
      pen_q       <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      pc_x_q[0]   <= '0;
      pc_x_q[1]   <= '0;
      pc_y_q[0]   <= '0;
      pc_y_q[1]   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // The emit step refills the output register itself.
      if (out_valid_q && !out_stall_i && state_q != StEmit) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgInvCap: ic_q <= cfg_data_i;
          CfgLetter: la_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            px_q <= point_x_i;
            py_q <= point_y_i;
            case (op_e'(operation_i))
              OpAdvance: pen_q <= sat32(pen_sum);
              OpContour, OpLine: begin
                cnt_q     <= '0;
                cur_x_q   <= sat_add(point_x_i, pen_q);
                cur_y_q   <= point_y_i;
                em_x_q    <= {sat_add(point_x_i, pen_q) < 0, sat_add(point_x_i, pen_q)};
                em_y_q    <= {point_y_i[31], point_y_i};
                em_newc_q <= op_e'(operation_i) == OpContour;
                em_last_q <= 1'b1;
                ret_q     <= StIdle;
                state_q   <= StScX;
              end
              default: begin
                // Spline point.
                lg_q  <= 1'b0;
                len_q <= '0;
                fin_q <= last_of_curve_i;
                if (cnt_q == 2'd2) begin
                  c_x_q     <= sat_add(pc_x_q[0], pen_q);
                  c_y_q     <= pc_y_q[0];
                  e_x_q     <= sat_add(half_floor(pc_x_q[1], point_x_i), pen_q);
                  e_y_q     <= half_floor(pc_y_q[1], point_y_i);
                  pc_x_q[0] <= pc_x_q[1];
                  pc_y_q[0] <= pc_y_q[1];
                  pc_x_q[1] <= point_x_i;
                  pc_y_q[1] <= point_y_i;
                  seg2_q    <= last_of_curve_i;
                  state_q   <= StLeg;
                  if (last_of_curve_i) begin
                    cnt_q <= '0;
                  end
                end else if (!last_of_curve_i) begin
                  pc_x_q[cnt_q[0]] <= point_x_i;
                  pc_y_q[cnt_q[0]] <= point_y_i;
                  cnt_q            <= cnt_q + 1'b1;
                end else if (cnt_q == 2'd1) begin
                  // One buffered control point: a single closing segment.
                  c_x_q   <= sat_add(pc_x_q[0], pen_q);
                  c_y_q   <= pc_y_q[0];
                  e_x_q   <= sat_add(point_x_i, pen_q);
                  e_y_q   <= point_y_i;
                  seg2_q  <= 1'b0;
                  cnt_q   <= '0;
                  state_q <= StLeg;
                end else begin
                  // Nothing buffered: the point itself only.
                  cur_x_q   <= sat_add(point_x_i, pen_q);
                  cur_y_q   <= point_y_i;
                  em_x_q    <= {sat_add(point_x_i, pen_q) < 0, sat_add(point_x_i, pen_q)};
                  em_y_q    <= {point_y_i[31], point_y_i};
                  em_newc_q <= 1'b0;
                  em_last_q <= 1'b1;
                  ret_q     <= StIdle;
                  cnt_q     <= '0;
                  state_q   <= StScX;
                end
              end
            endcase
          end
        end
        StScX: state_q <= StScY;
        StScY: begin
          rx_q    <= scale_res(prod, em_x_q[32]);
          state_q <= StScW;
        end
        StScW: begin
          ry_q    <= scale_res(prod, em_y_q[32]);
          state_q <= StEmit;
        end
        StEmit: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_x_q     <= rx_q;
            out_y_q     <= ry_q;
            out_newc_q  <= em_newc_q;
            out_last_q  <= em_last_q;
            state_q     <= ret_q;
          end
        end
        StLeg: begin
          // Halve both legs when either is too large for the square.
          hv_q    <= adx[31] | ady[31];
          a_q     <= (adx[31] | ady[31]) ? adx[31:1] : adx[30:0];
          b_q     <= (adx[31] | ady[31]) ? ady[31:1] : ady[30:0];
          state_q <= StSqA;
        end
        StSqA: state_q <= StSqB;
        StSqB: begin
          sq_q    <= prod[61:0];
          state_q <= StSqSum;
        end
        StSqSum: state_q <= StSqWait;
        StSqWait: begin
          if (sq_done) begin
            len_q <= len_q + (hv_q ? {1'b0, sq_root, 1'b0} : {2'b00, sq_root});
            if (!lg_q) begin
              lg_q    <= 1'b1;
              state_q <= StLeg;
            end else begin
              state_q <= StStMul;
            end
          end
        end
        StStMul: state_q <= StStCalc;
        StStCalc: begin
          if (st_raw < 17'(MinSteps)) begin
            st_q <= StW'(MinSteps);
          end else if (st_raw > 17'(MAX_STEPS)) begin
            st_q <= StW'(MAX_STEPS);
          end else begin
            st_q <= st_raw[StW-1:0];
          end
          s_q     <= StW'(1);
          ax_q    <= 1'b0;
          state_q <= StPtA;
        end
        StPtA: state_q <= StPtB;
        StPtB: begin
          acc_q   <= prod[NumW-1:0];
          state_q <= StPtC;
        end
        StPtC: begin
          acc_q   <= acc_q + prod[NumW-1:0];
          state_q <= StPtD;
        end
        StPtD: begin
          neg_q   <= num[NumW-1];
          state_q <= StPtDiv;
        end
        StPtDiv: begin
          if (dv_done) begin
            if (!ax_q) begin
              em_x_q  <= neg_q ? -q33 : q33;
              ax_q    <= 1'b1;
              state_q <= StPtA;
            end else begin
              em_y_q    <= neg_q ? -q33 : q33;
              ax_q      <= 1'b0;
              em_newc_q <= 1'b0;
              em_last_q <= (s_q == st_q) && !fin_q;
              ret_q     <= StPtNext;
              state_q   <= StScX;
            end
          end
        end
        StPtNext: begin
          if (s_q != st_q) begin
            s_q     <= s_q + 1'b1;
            state_q <= StPtA;
          end else begin
            cur_x_q <= e_x_q;
            cur_y_q <= e_y_q;
            if (seg2_q) begin
              // Closing segment of the record on the last spline point.
              c_x_q   <= sat_add(pc_x_q[0], pen_q);
              c_y_q   <= pc_y_q[0];
              e_x_q   <= sat_add(px_q, pen_q);
              e_y_q   <= py_q;
              seg2_q  <= 1'b0;
              lg_q    <= 1'b0;
              len_q   <= '0;
              state_q <= StLeg;
            end else if (fin_q) begin
              em_x_q    <= {e_x_q[31], e_x_q};
              em_y_q    <= {e_y_q[31], e_y_q};
              em_newc_q <= 1'b0;
              em_last_q <= 1'b1;
              ret_q     <= StIdle;
              state_q   <= StScX;
            end else begin
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o    = state_q != StIdle;
  assign out_valid_o   = out_valid_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign new_contour_o = out_newc_q;
  assign last_o        = out_last_q;

endmodule

[hdl/gof_mul.sv]
// Shared signed multiplier with a registered product.
module gof_mul
  import gof_pkg::*;
(
  input  logic                     clk_i,
  input  logic signed [MulW-1:0]   a_i,
  input  logic signed [MulW-1:0]   b_i,
  output logic signed [2*MulW-1:0] prod_o
);

  logic signed [2*MulW-1:0] prod_q;

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

[hdl/gof_sqrt.sv]
// Iterative integer square root, two radicand bits per cycle.
module gof_sqrt
  import gof_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SqRadW-1:0]  rad_i,
  output logic               done_o,
  output logic [SqRootW-1:0] root_o
);

  localparam int unsigned CntW = $clog2(SqRootW + 1);

  logic [SqRadW-1:0]  x_q;
  logic [SqRootW+1:0] rem_q;
  logic [SqRootW-1:0] root_q;
  logic [CntW-1:0]    cnt_q;
  logic               busy_q;
  logic               done_q;

  logic [SqRootW+3:0] rem_sh;
  logic [SqRootW+3:0] trial;
  logic               ge;

  // Bring down two bits and try the next root bit.
  assign rem_sh = {rem_q, x_q[SqRadW-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        x_q    <= rad_i;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= CntW'(SqRootW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q  <= ge ? (SqRootW + 2)'(rem_sh - trial) : (SqRootW + 2)'(rem_sh);
        root_q <= {root_q[SqRootW-2:0], ge};
        x_q    <= {x_q[SqRadW-3:0], 2'b00};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[hdl/gof_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module gof_div #(
  parameter int unsigned DW = 42,
  parameter int unsigned VW = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DW + 1);

  logic [DW-1:0]   dvd_q;
  logic [VW-1:0]   dsr_q;
  logic [VW-1:0]   rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;

  logic [VW:0] rem_sh;
  logic        ge;

  // Shift in the next dividend bit and subtract where it fits.
  assign rem_sh = {rem_q, dvd_q[DW-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dvd_q  <= dividend_i;
        dsr_q  <= divisor_i;
        rem_q  <= '0;
        cnt_q  <= CntW'(DW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q  <= ge ? VW'(rem_sh - {1'b0, dsr_q}) : VW'(rem_sh);
        dvd_q  <= {dvd_q[DW-2:0], ge};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

[hdl/gof_checker.sv]
// Port-level checks of the glyph outline flattener and their binding.
module gof_checker
  import gof_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         operation_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] out_x_o,
  input logic signed [31:0] out_y_o,
  input logic               new_contour_o,
  input logic               last_o
);

  // A stalled result item stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_x_o) && $stable(out_y_o))
    else $error("stalled result item changed");

  // A contour start or line point keeps the block busy while it is scaled.
  a_point_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (operation_i == OpContour || operation_i == OpLine) |=> in_stall_o)
    else $error("block ready right after a point item");

  // A pen advance leaves the block ready for the next item.
  a_adv_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && operation_i == OpAdvance |=> !in_stall_o)
    else $error("pen advance held the block");

  // A contour start result item is marked as the last one.
  a_contour_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && new_contour_o |-> last_o)
    else $error("contour start result not marked last");

endmodule

bind glyph_outline_flattener_top gof_checker u_gof_checker (.*);

[tb/gof_outline_checker.sv]
// Checker of the glyph outline flattener: predicts the emitted points and compares them.
module gof_outline_checker
  import gof_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [15:0] advance_i,
  input  logic               last_of_curve_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] out_x_i,
  input  logic signed [31:0] out_y_i,
  input  logic               new_contour_i,
  input  logic               last_i,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int                 errors_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               nc;
    logic               lst;
  } point_t;

  point_t expected_points[$];

  // Predicted configuration and outline state.
  logic [31:0] inv_cap;
  longint      letter_adv;
  longint      pen;
  longint      cur_x, cur_y;
  longint      buf_x[2], buf_y[2];
  int          buf_cnt;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mean_floor(longint a, longint b);
    return (a + b) >>> 1;
  endfunction

  // Scale by the reciprocal cap height, round half away from zero.
  function automatic longint scale_coord(longint v);
    bit [63:0] m, r;
    m = (v < 0) ? -v : v;
    r = (m * {32'b0, inv_cap} + 64'h8000_0000) >> 32;
    return clip32((v < 0) ? -longint'(r) : longint'(r));
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] x);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit [63:0] leg_length(longint dx, longint dy);
    bit [63:0] a, b;
    a = (dx < 0) ? -dx : dx;
    b = (dy < 0) ? -dy : dy;
    if (a >= 64'h8000_0000 || b >= 64'h8000_0000) begin
      a >>= 1;
      b >>= 1;
      return int_sqrt(a * a + b * b) * 2;
    end
    return int_sqrt(a * a + b * b);
  endfunction

  function automatic longint round_div(longint num, longint den);
    bit [63:0] m, q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void add_point(longint x, longint y, bit nc);
    point_t p;
    p.x = scale_coord(x);
    p.y = scale_coord(y);
    p.nc = nc;
    p.lst = 1'b0;
    expected_points = {expected_points, p};
  endfunction

  // Flatten one quadratic segment from the current point through c to e.
  function automatic void flatten_segment(longint cx, longint cy, longint ex, longint ey);
    bit [63:0] len, v, st;
    longint    n, nn, a, b, c;
    len = leg_length(cx - cur_x, cy - cur_y) + leg_length(ex - cx, ey - cy);
    v = (len >> 2) * {32'b0, inv_cap} + (((len & 64'd3) * {32'b0, inv_cap}) >> 2);
    st = v >> 48;
    if (st < MinSteps) st = MinSteps;
    if (st > MaxStepsDef) st = MaxStepsDef;
    n = longint'(st) + 1;
    nn = n * n;
    for (longint s = 1; s <= longint'(st); s++) begin
      a = (n - s) * (n - s);
      b = 2 * s * (n - s);
      c = s * s;
      add_point(round_div(a * cur_x + b * cx + c * ex, nn),
                round_div(a * cur_y + b * cy + c * ey, nn), 1'b0);
    end
    cur_x = ex;
    cur_y = ey;
  endfunction

  // Work out the points caused by one accepted item.
  function automatic void predict_outline_item(op_e op, longint px, longint py,
                                               longint adv, bit lst);
    int     first, had;
    longint ex;
    first = expected_points.size();
    case (op)
      OpAdvance: begin
        pen = clip32(pen + adv * 65536 + letter_adv);
      end
      OpContour, OpLine: begin
        buf_cnt = 0;
        cur_x = clip32(px + pen);
        cur_y = py;
        add_point(cur_x, cur_y, op == OpContour);
      end
      default: begin
        had = buf_cnt;
        if (had == 2) begin
          flatten_segment(clip32(buf_x[0] + pen), buf_y[0],
                          clip32(mean_floor(buf_x[1], px) + pen), mean_floor(buf_y[1], py));
          buf_x[0] = buf_x[1];
          buf_y[0] = buf_y[1];
          buf_x[1] = px;
          buf_y[1] = py;
        end else if (!lst) begin
          buf_x[had] = px;
          buf_y[had] = py;
          buf_cnt = had + 1;
        end
        if (lst) begin
          ex = clip32(px + pen);
          if (had >= 1) flatten_segment(clip32(buf_x[0] + pen), buf_y[0], ex, py);
          cur_x = ex;
          cur_y = py;
          add_point(ex, py, 1'b0);
          buf_cnt = 0;
        end
      end
    endcase
    if (expected_points.size() > first) expected_points[expected_points.size() - 1].lst = 1'b1;
  endfunction

  // Compare taken points first, then predict from a newly taken item.
  always @(posedge clk_i or negedge rst_ni) begin
    point_t e;
    if (!rst_ni) begin
      inv_cap = InvCapReset;
      letter_adv = 0;
      pen = 0;
      cur_x = 0;
      cur_y = 0;
      buf_x = '{0, 0};
      buf_y = '{0, 0};
      buf_cnt = 0;
      errors_o = 0;
      expected_points.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          $error("unexpected point x=%0d y=%0d", out_x_i, out_y_i);
          errors_o++;
        end else begin
          e = expected_points.pop_front();
          if (out_x_i !== e.x) begin
            $error("out_x expected %0d actual %0d", e.x, out_x_i);
            errors_o++;
          end
          if (out_y_i !== e.y) begin
            $error("out_y expected %0d actual %0d", e.y, out_y_i);
            errors_o++;
          end
          if (new_contour_i !== e.nc) begin
            $error("new_contour expected %0d actual %0d", e.nc, new_contour_i);
            errors_o++;
          end
          if (last_i !== e.lst) begin
            $error("last expected %0d actual %0d", e.lst, last_i);
            errors_o++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CfgInvCap) inv_cap = cfg_data_i;
        else letter_adv = longint'($signed(cfg_data_i));
      end
      if (in_valid_i && !in_stall_i) begin
        predict_outline_item(op_e'(operation_i), longint'(point_x_i), longint'(point_y_i),
                             longint'(advance_i), last_of_curve_i);
      end
    end
    pending_o = expected_points.size();
  end

endmodule

[tb/tb.sv]
// Testbench top of the glyph outline flattener: stimulus, receiver stalls and verdict.
module tb
  import gof_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         operation = OpContour;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic signed [15:0] advance = '0;
  logic               last_of_curve = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_x, out_y;
  logic               new_contour, last;
  logic               cfg_we = 1'b0;
  logic               cfg_index = CfgInvCap;
  logic [31:0]        cfg_data = '0;
  int                 errors, pending;
  int                 items_sent = 0;
  bit                 sender_burst = 1'b0;
  bit                 receiver_burst = 1'b0;
  bit                 long_hold_done = 1'b0;

  always #5 clk_i = ~clk_i;

  glyph_outline_flattener_top DUT (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .operation_i(operation), .point_x_i(point_x), .point_y_i(point_y),
    .advance_i(advance), .last_of_curve_i(last_of_curve),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_x_o(out_x), .out_y_o(out_y), .new_contour_o(new_contour), .last_o(last),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  gof_outline_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .operation_i(operation), .point_x_i(point_x), .point_y_i(point_y),
    .advance_i(advance), .last_of_curve_i(last_of_curve),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_x_i(out_x), .out_y_i(out_y), .new_contour_i(new_contour), .last_i(last),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  // Offer one item after a random gap and hold it until the block takes it.
  task automatic send_point(op_e op, logic [31:0] x, logic [31:0] y,
                            logic [15:0] adv, logic lst);
    int gap;
    if ($urandom_range(0, 15) == 0) sender_burst = !sender_burst;
    gap = sender_burst ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    operation = op;
    point_x = x;
    point_y = y;
    advance = adv;
    last_of_curve = lst;
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    @(negedge clk_i);
    in_valid = 1'b0;
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // Let every expected point arrive, then give the block time to settle.
  task automatic drain;
    @(negedge clk_i);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return 32'hffff_ffff;
        endcase
      end
      1: return $urandom;
      default: return $urandom_range(0, 2000 << 16) - (1000 << 16);
    endcase
  endfunction

  // Random outline records: mostly contours, lines and spline runs, some noise.
  task automatic random_outline(int count);
    int stop, run;
    stop = items_sent + count;
    while (items_sent < stop) begin
      case ($urandom_range(0, 9))
        0: send_point(op_e'($urandom_range(0, 3)), $urandom, $urandom, 16'($urandom),
                      1'($urandom_range(0, 1)));
        1: send_point(OpAdvance, $urandom, $urandom, 16'($urandom_range(0, 2000) - 1000),
                      1'($urandom_range(0, 1)));
        2: send_point(OpContour, pick_coord(), pick_coord(), 16'($urandom), 1'b0);
        3, 4: send_point(OpLine, pick_coord(), pick_coord(), 16'($urandom),
                         1'($urandom_range(0, 1)));
        default: begin
          run = $urandom_range(1, 4);
          for (int i = 1; i <= run; i++) begin
            send_point(OpSpline, pick_coord(), pick_coord(), 16'($urandom), i == run);
          end
        end
      endcase
    end
  endtask

  // Receiver: random stalls, one long hold-off to back the block up.
  initial begin
    int wait_cycles, taken;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 15) == 0) receiver_burst = !receiver_burst;
      if (!long_hold_done && taken == 30) begin
        wait_cycles = 600;
        long_hold_done = 1'b1;
      end else begin
        wait_cycles = receiver_burst ? 0 : $urandom_range(0, 10);
      end
      @(negedge clk_i);
      out_stall = (wait_cycles > 0);
      repeat (wait_cycles) @(negedge clk_i);
      out_stall = 1'b0;
      do @(posedge clk_i); while (!out_valid);
      taken++;
    end
  end

  // Stimulus and verdict.
  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed outline at the default scale.
    send_point(OpContour, 32'h7fff_ffff, 32'h8000_0000, 16'h0, 1'b1);
    send_point(OpLine, 32'h8000_0000, 32'h7fff_ffff, 16'h0, 1'b0);
    send_point(OpSpline, 32'h0010_0000, 32'h0020_0000, 16'h0, 1'b1);
    send_point(OpSpline, 32'h1000_0000, 32'h0, 16'h0, 1'b0);
    send_point(OpSpline, 32'h2000_0000, 32'h3000_0000, 16'h0, 1'b1);
    send_point(OpContour, 32'h0, 32'h0, 16'h0, 1'b0);
    send_point(OpSpline, 32'h4000_0000, 32'h4000_0000, 16'h0, 1'b0);
    send_point(OpSpline, 32'hc000_0000, 32'h7fff_ffff, 16'h0, 1'b0);
    send_point(OpAdvance, 32'hffff_ffff, 32'hffff_ffff, 16'h7fff, 1'b1);
    send_point(OpSpline, 32'h8000_0000, 32'h8000_0000, 16'h0, 1'b0);
    send_point(OpSpline, 32'h0123_4567, 32'hfedc_ba98, 16'h0, 1'b1);
    // A contour start drops an open spline record.
    send_point(OpSpline, 32'h0100_0000, 32'h0200_0000, 16'h0, 1'b0);
    send_point(OpContour, 32'hffff_0000, 32'h0001_0000, 16'h0, 1'b1);
    send_point(OpSpline, 32'h0300_0000, 32'h0100_0000, 16'h0, 1'b0);
    send_point(OpLine, 32'h0, 32'hffff_ffff, 16'h0, 1'b1);
    send_point(OpAdvance, 32'h0, 32'h0, 16'h8000, 1'b0);
    send_point(OpAdvance, 32'h0, 32'h0, 16'h8000, 1'b0);
    send_point(OpLine, 32'h0000_ffff, 32'h0, 16'h0, 1'b0);
    drain();

    // Extreme and ordinary register settings, each with random outlines.
    write_reg(CfgInvCap, 32'hffff_ffff);
    write_reg(CfgLetter, 32'h7fff_ffff);
    send_point(OpAdvance, 32'h0, 32'h0, 16'h0, 1'b0);
    send_point(OpSpline, 32'h0080_0000, 32'h0, 16'h0, 1'b0);
    send_point(OpSpline, 32'h0100_0000, 32'h0080_0000, 16'h0, 1'b1);
    random_outline(22);
    drain();

    write_reg(CfgInvCap, 32'h0);
    write_reg(CfgLetter, 32'h8000_0000);
    send_point(OpAdvance, 32'h0, 32'h0, 16'h8000, 1'b0);
    random_outline(20);
    drain();

    write_reg(CfgInvCap, 32'h1);
    write_reg(CfgLetter, $urandom);
    random_outline(20);
    drain();

    write_reg(CfgLetter, $urandom_range(0, 64 << 16) - (32 << 16));
    write_reg(CfgInvCap, $urandom_range(1 << 20, 1 << 24));
    random_outline(25);
    drain();

    write_reg(CfgInvCap, InvCapReset);
    write_reg(CfgLetter, 32'h0);
    random_outline(25);
    drain();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #30ms;
    $display("FAIL");
    $finish;
  end

endmodule
